// ===== rtl/hcbd_pkg.sv =====
// Shared types and constants for the HTTP chunked body decoder.
// No dependencies; imported by every rtl module of the block.
package hcbd_pkg;

   localparam int SIZE_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH       = 4;

   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_END     = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      PH_SKIP_WS  = 4'd0,
      PH_DIGITS   = 4'd1,
      PH_EXT      = 4'd2,
      PH_SIZE_LF  = 4'd3,
      PH_DATA     = 4'd4,
      PH_TRAIL_CR = 4'd5,
      PH_TRAIL_LF = 4'd6,
      PH_DONE     = 4'd7,
      PH_ERROR    = 4'd8
   } phase_type;

   // One classified request as it sits in the queue.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       message_start;
      logic       is_hex;
      logic [3:0] hex_digit;
      logic       is_space;
      logic       is_cr;
      logic       is_lf;
   } class_type;

endpackage

// ===== rtl/http_chunked_body_decoder_top.sv =====
// Top level of the HTTP/1.1 chunked body decoder.
// Depends on hcbd_pkg, hcbd_front, hcbd_queue and hcbd_back.
//
// Usage:
//   Request channel (req_*): one raw body byte per request. req_tuser marks a
//   message start; that byte is parsed from a cleared decoder state.
//   Response channel (rsp_*): at most one response per request byte: a payload
//   byte, a last-chunk marker, or a framing error (sticky until message start).
//   Leading whitespace, size digits, chunk extensions, CR LF and trailers give
//   no response.
// Throughput: one request per clock, sustained while rsp_tready stays high. A
//   four-entry queue sits between the classifier and the framing state machine,
//   so request intake keeps running while a response waits in the output register.
// Path: the queue entry is written at the accepting edge; the response register
//   loads when the framing state machine pops that entry.
// Reset: synchronous, active high; empties the queue, drops any pending
//   response and returns the parser to waiting for a chunk size.
// Stall: with rsp_tready low and a response pending, the response register holds;
//   the queue then fills and req_tready drops when it is full.
module http_chunked_body_decoder_top #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] message_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic [1:0] rsp_tuser    // [1:0] result_kind
);
   import hcbd_pkg::*;

   logic      q_wr_valid, q_wr_ready;
   class_type q_wr_data;
   logic      q_rd_valid, q_rd_ready;
   class_type q_rd_data;

   // classify each request byte as it arrives
   hcbd_front u_front (
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .data_byte     (req_tdata),
      .message_start (req_tuser),
      .q_wr_valid    (q_wr_valid),
      .q_wr_ready    (q_wr_ready),
      .q_wr_data     (q_wr_data)
   );

   // decouples intake from the framing state machine
   hcbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_data  (q_wr_data),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready),
      .rd_data  (q_rd_data)
   );

   // framing state machine; pops one entry per cycle unless the response stalls
   hcbd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_rd_valid),
      .q_ready      (q_rd_ready),
      .q_data       (q_rd_data),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .result_kind  (rsp_tuser),
      .payload_byte (rsp_tdata)
   );

endmodule

// ===== rtl/hcbd_front.sv =====
// Front end: takes request bytes and classifies them (hex digit, whitespace, CR, LF).
// Depends on hcbd_pkg.
module hcbd_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           data_byte,
   input  logic                 message_start,
   output logic                 q_wr_valid,
   input  logic                 q_wr_ready,
   output hcbd_pkg::class_type  q_wr_data
);
   import hcbd_pkg::*;

   logic [7:0] c;

   assign c          = data_byte;
   assign req_ready  = q_wr_ready;
   assign q_wr_valid = req_valid;

   always_comb begin
      q_wr_data               = '0;
      q_wr_data.data_byte     = c;
      q_wr_data.message_start = message_start;
      q_wr_data.is_cr         = (c == CHAR_CR);
      q_wr_data.is_lf         = (c == CHAR_LF);
      q_wr_data.is_space      = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) ||
                                (c == CHAR_VT) || (c == CHAR_FF) || (c == CHAR_CR);
      if (c >= 8'h30 && c <= 8'h39) begin
         q_wr_data.is_hex    = 1'b1;
         q_wr_data.hex_digit = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         // a..f and A..F share low bits 1..6
         q_wr_data.is_hex    = 1'b1;
         q_wr_data.hex_digit = c[3:0] + 4'd9;
      end
   end

endmodule

// ===== rtl/hcbd_queue.sv =====
// Short queue of classified requests between front end and back end.
// Depends on hcbd_pkg.
module hcbd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  hcbd_pkg::class_type  wr_data,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output hcbd_pkg::class_type  rd_data
);
   import hcbd_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   class_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign wr_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_BITS'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_BITS'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/hcbd_back.sv =====
// Back end: chunk framing state machine plus the registered result stage.
// Depends on hcbd_pkg.
module hcbd_back #(
   parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  hcbd_pkg::class_type  q_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           result_kind,
   output logic [7:0]           payload_byte
);
   import hcbd_pkg::*;

   phase_type            phase_ff, phase_in, phase_cur;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in, remaining_cur, remaining_dec;
   logic                 rsp_valid_ff, rsp_valid_in;
   kind_type             kind_ff, kind_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 take, emit;
   logic                 size_full;

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign take    = q_valid && q_ready;

   // message_start restarts the parse on this very byte
   assign phase_cur     = q_data.message_start ? PH_SKIP_WS : phase_ff;
   assign remaining_cur = q_data.message_start ? '0 : remaining_ff;
   assign remaining_dec = remaining_cur - 1'b1;
   assign size_full     = (remaining_cur[SIZE_BITS-1 -: 4] != 4'd0);

   // next state
   always_comb begin
      phase_in     = phase_cur;
      remaining_in = remaining_cur;
      case (phase_cur)
         PH_SKIP_WS: begin
            if (!q_data.is_space) begin
               if (q_data.is_hex) begin
                  phase_in     = PH_DIGITS;
                  remaining_in = SIZE_BITS'(q_data.hex_digit);
               end else begin
                  phase_in     = PH_ERROR;
                  remaining_in = '0;
               end
            end
         end
         PH_DIGITS: begin
            if (q_data.is_hex) begin
               if (size_full) begin
                  phase_in     = PH_ERROR;
                  remaining_in = '0;
               end else begin
                  remaining_in = {remaining_cur[SIZE_BITS-5:0], q_data.hex_digit};
               end
            end else begin
               phase_in = q_data.is_cr ? PH_SIZE_LF : PH_EXT;
            end
         end
         PH_EXT: begin
            if (q_data.is_cr) begin
               phase_in = PH_SIZE_LF;
            end
         end
         PH_SIZE_LF: begin
            if (!q_data.is_lf) begin
               phase_in     = PH_ERROR;
               remaining_in = '0;
            end else if (remaining_cur == '0) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               phase_in = PH_TRAIL_CR;
            end
         end
         PH_TRAIL_CR: begin
            if (!q_data.is_cr) begin
               phase_in     = PH_ERROR;
               remaining_in = '0;
            end else begin
               phase_in = PH_TRAIL_LF;
            end
         end
         PH_TRAIL_LF: begin
            if (!q_data.is_lf) begin
               phase_in = PH_ERROR;
            end else begin
               phase_in = PH_SKIP_WS;
            end
            remaining_in = '0;
         end
         default: begin
            phase_in     = phase_cur;
            remaining_in = remaining_cur;
         end
      endcase
   end

   // result of the byte being taken
   always_comb begin
      emit    = 1'b0;
      kind_in = KIND_PAYLOAD;
      byte_in = 8'd0;
      case (phase_cur)
         PH_SKIP_WS: begin
            if (!q_data.is_space && !q_data.is_hex) begin
               emit    = 1'b1;
               kind_in = KIND_ERROR;
            end
         end
         PH_DIGITS: begin
            if (q_data.is_hex && size_full) begin
               emit    = 1'b1;
               kind_in = KIND_ERROR;
            end
         end
         PH_SIZE_LF: begin
            if (!q_data.is_lf) begin
               emit    = 1'b1;
               kind_in = KIND_ERROR;
            end else if (remaining_cur == '0) begin
               emit    = 1'b1;
               kind_in = KIND_END;
            end
         end
         PH_DATA: begin
            emit    = 1'b1;
            kind_in = KIND_PAYLOAD;
            byte_in = q_data.data_byte;
         end
         PH_TRAIL_CR: begin
            if (!q_data.is_cr) begin
               emit    = 1'b1;
               kind_in = KIND_ERROR;
            end
         end
         PH_TRAIL_LF: begin
            if (!q_data.is_lf) begin
               emit    = 1'b1;
               kind_in = KIND_ERROR;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP_WS;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff     <= phase_in;
            remaining_ff <= remaining_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign result_kind  = kind_ff;
   assign payload_byte = byte_ff;

endmodule
